FILE: sv/tmc_pkg.sv
// shared types, constants and helper functions of the touch to midi controller
package tmc_pkg;

  // one input request: a frame of events or a key table load
  typedef struct packed {
    logic       req_type;
    logic [6:0] pressed_mask;
    logic       touch_released;
    logic       touch_held;
    logic [7:0] pen_x;
    logic [7:0] pen_y;
    logic [7:0] entry_index;
    logic [6:0] entry_note;
  } in_req_t;

  // one midi message as delivered on the result side
  typedef struct packed {
    logic [7:0] midi_status;
    logic [6:0] data_one;
    logic [6:0] data_two;
    logic       last_of_run;
  } out_res_t;

  // one message inside a frame plan
  typedef struct packed {
    logic [7:0] status;
    logic [6:0] d1;
    logic [6:0] d2;
  } msg_t;

  localparam int MAX_MSGS    = 4;
  localparam int QUEUE_DEPTH = 2;

  // all messages of one frame, oldest in slot 0
  typedef struct packed {
    msg_t [MAX_MSGS-1:0] msgs;
    logic [1:0]          last_idx;
  } plan_t;

  // key rectangle settings, in tiles of eight pixels
  typedef struct packed {
    logic [4:0] col;
    logic [4:0] row;
    logic [4:0] cols;
    logic [2:0] rows;
  } area_cfg_t;

  // register map, word index into the configuration space
  typedef enum logic [1:0] {
    REG_AREA_COL  = 2'd0,
    REG_AREA_ROW  = 2'd1,
    REG_AREA_COLS = 2'd2,
    REG_AREA_ROWS = 2'd3
  } reg_idx_t;

  localparam logic [4:0] AREA_COL_RST  = 5'd2;
  localparam logic [4:0] AREA_ROW_RST  = 5'd10;
  localparam logic [4:0] AREA_COLS_RST = 5'd28;
  localparam logic [2:0] AREA_ROWS_RST = 3'd5;

  // status nibbles, the channel fills the low nibble
  localparam logic [3:0] ST_NOTE_ON  = 4'h9;
  localparam logic [3:0] ST_NOTE_OFF = 4'h8;
  localparam logic [3:0] ST_BEND     = 4'hE;
  localparam logic [3:0] ST_CTRL     = 4'hB;

  // button positions in pressed_mask
  localparam int BTN_TOUCH = 0;
  localparam int BTN_X     = 1;
  localparam int BTN_Y     = 2;
  localparam int BTN_RIGHT = 3;
  localparam int BTN_LEFT  = 4;
  localparam int BTN_UP    = 5;
  localparam int BTN_DOWN  = 6;

  localparam logic [6:0] VEL_ON        = 7'd127;
  localparam logic [6:0] VEL_OFF       = 7'd0;
  localparam logic [6:0] BEND_CENTER   = 7'd64;
  localparam logic [6:0] BEND_LSB      = 7'd0;
  localparam logic [6:0] CTRL_PRESSURE = 7'd0;
  localparam logic [6:0] PRESSURE_MAX  = 7'd127;
  localparam logic [6:0] PRESSURE_ZERO = 7'd0;
  localparam logic [8:0] NOTE_MAX      = 9'd127;
  localparam logic [8:0] NOTE_STEP     = 9'd12;
  localparam logic [3:0] OCT_MAX       = 4'd9;
  localparam logic [3:0] OCT_RST       = 4'd2;
  localparam logic [3:0] CHAN_MAX      = 4'd15;

  // note plus twelve per octave, saturated at the top of the midi range
  function automatic logic [6:0] full_note(input logic [6:0] note, input logic [3:0] oct);
    logic [8:0] sum;
    sum = {2'b00, note} + NOTE_STEP * {5'b0, oct};
    if (sum > NOTE_MAX) begin
      return NOTE_MAX[6:0];
    end
    return sum[6:0];
  endfunction

  // signed drag clamped to -64..63 and moved to 0..127
  function automatic logic [6:0] bend_value(input logic signed [8:0] drag);
    logic signed [8:0] shifted;
    shifted = drag + 9'sd64;
    if (drag < -9'sd64) begin
      return 7'd0;
    end else if (drag > 9'sd63) begin
      return 7'd127;
    end
    return shifted[6:0];
  endfunction

endpackage

FILE: sv/tmc_queue.sv
// small fifo of frame plans between the front and the back
module tmc_queue
  import tmc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  plan_t wr_plan,
  output logic  full,
  input  logic  pop,
  output plan_t rd_plan,
  output logic  empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  plan_t              slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_plan = slot_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // plan storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_plan;
    end
  end

endmodule

FILE: sv/tmc_front.sv
// front end: accepts requests, holds the key table and builds the plan of each frame
module tmc_front
  import tmc_pkg::*;
#(
  parameter int TABLE_ROWS = 5,
  parameter int TABLE_COLS = 28
)(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_req_t   in_data,
  input  area_cfg_t area,
  output logic      q_push,
  output plan_t     q_plan,
  input  logic      q_full
);

  localparam int TABLE_SIZE = TABLE_ROWS * TABLE_COLS;
  localparam int ADDR_W     = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

  logic [6:0]        key_mem [TABLE_SIZE];
  logic [6:0]        rd_note_r;

  logic              accept;
  logic [9:0]        px_ext, py_ext, x_lo, x_hi, y_lo, y_hi;
  logic [5:0]        col_end, row_end;
  logic [4:0]        kx, ky;
  logic              in_rect, key_hit;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              wr_ok;

  logic              s1_valid_r, s1_valid_nxt;
  in_req_t           s1_req_r;
  logic              s1_hit_r;
  logic              s1_adv;

  logic              pen_r, pen_nxt;
  logic [7:0]        ox_r, ox_nxt, oy_r, oy_nxt;
  logic [6:0]        held_r, held_nxt;
  logic [3:0]        oct_r, oct_nxt, chan_r, chan_nxt;

  msg_t [MAX_MSGS-1:0] msgs;
  logic [2:0]          n;
  logic signed [8:0]   dx, drag;
  logic [6:0]          press;

  assign accept = push && !full;
  assign full   = s1_valid_r && q_full;
  assign s1_adv = s1_valid_r && !q_full;

  // key rectangle test and table address of the touched tile
  always_comb begin
    px_ext  = {2'b00, in_data.pen_x};
    py_ext  = {2'b00, in_data.pen_y};
    col_end = 6'(area.col) + 6'(area.cols);
    row_end = 6'(area.row) + 6'(area.rows);
    x_lo    = {2'b00, area.col, 3'b000};
    x_hi    = {1'b0, col_end, 3'b000};
    y_lo    = {2'b00, area.row, 3'b000};
    y_hi    = {1'b0, row_end, 3'b000};
    in_rect = (px_ext > x_lo) && (py_ext > y_lo) && (px_ext < x_hi) && (py_ext < y_hi);
    kx      = in_data.pen_x[7:3] - area.col;
    ky      = in_data.pen_y[7:3] - area.row;
    key_hit = in_rect && ({1'b0, kx} < 6'(TABLE_COLS)) && ({1'b0, ky} < 6'(TABLE_ROWS));
    rd_addr = key_hit ? ADDR_W'(int'(ky) * TABLE_COLS + int'(kx)) : '0;
    wr_ok   = {1'b0, in_data.entry_index} < 9'(TABLE_SIZE);
    wr_addr = in_data.entry_index[ADDR_W-1:0];
  end

  // key table: loads write, frames read with registered data
  always_ff @(posedge clk) begin
    if (accept && in_data.req_type && wr_ok) begin
      key_mem[wr_addr] <= in_data.entry_note;
    end
    if (accept && !in_data.req_type) begin
      rd_note_r <= key_mem[rd_addr];
    end
  end

  // classify stage register
  assign s1_valid_nxt = accept || (s1_valid_r && !s1_adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req_r <= in_data;
      s1_hit_r <= key_hit;
    end
  end

  // frame plan and next controller state
  always_comb begin
    msgs     = '0;
    n        = 3'd0;
    pen_nxt  = pen_r;
    ox_nxt   = ox_r;
    oy_nxt   = oy_r;
    held_nxt = held_r;
    oct_nxt  = oct_r;
    chan_nxt = chan_r;
    dx       = $signed({1'b0, s1_req_r.pen_x}) - $signed({1'b0, ox_r});
    drag     = $signed({1'b0, oy_r}) - $signed({1'b0, s1_req_r.pen_y});
    if (dx[8]) begin
      press = PRESSURE_ZERO;
    end else if (dx[7]) begin
      press = PRESSURE_MAX;
    end else begin
      press = dx[6:0];
    end

    // touch messages
    if (!pen_r && s1_req_r.pressed_mask[BTN_TOUCH]) begin
      pen_nxt = 1'b1;
      ox_nxt  = s1_req_r.pen_x;
      oy_nxt  = s1_req_r.pen_y;
      if (s1_hit_r) begin
        held_nxt      = rd_note_r;
        msgs[n[1:0]]  = '{status: {ST_NOTE_ON, chan_r}, d1: full_note(rd_note_r, oct_r),
                          d2: VEL_ON};
        n             = n + 3'd1;
      end
    end else if (s1_req_r.touch_released) begin
      pen_nxt      = 1'b0;
      msgs[n[1:0]] = '{status: {ST_NOTE_OFF, chan_r}, d1: full_note(held_r, oct_r),
                       d2: VEL_OFF};
      n            = n + 3'd1;
      msgs[n[1:0]] = '{status: {ST_BEND, chan_r}, d1: BEND_LSB, d2: BEND_CENTER};
      n            = n + 3'd1;
    end else if (pen_r && s1_req_r.touch_held) begin
      msgs[n[1:0]] = '{status: {ST_BEND, chan_r}, d1: BEND_LSB, d2: bend_value(drag)};
      n            = n + 3'd1;
      msgs[n[1:0]] = '{status: {ST_CTRL, chan_r}, d1: CTRL_PRESSURE, d2: press};
      n            = n + 3'd1;
    end

    // reset buttons
    if (s1_req_r.pressed_mask[BTN_X]) begin
      msgs[n[1:0]] = '{status: {ST_BEND, chan_r}, d1: BEND_LSB, d2: BEND_CENTER};
      n            = n + 3'd1;
    end
    if (s1_req_r.pressed_mask[BTN_Y]) begin
      msgs[n[1:0]] = '{status: {ST_CTRL, chan_r}, d1: CTRL_PRESSURE, d2: PRESSURE_ZERO};
      n            = n + 3'd1;
    end

    // octave and channel steps take effect after this frame
    if (s1_req_r.pressed_mask[BTN_RIGHT] && (oct_nxt < OCT_MAX)) begin
      oct_nxt = oct_nxt + 4'd1;
    end
    if (s1_req_r.pressed_mask[BTN_LEFT] && (oct_nxt != 4'd0)) begin
      oct_nxt = oct_nxt - 4'd1;
    end
    if (s1_req_r.pressed_mask[BTN_UP] && (chan_nxt < CHAN_MAX)) begin
      chan_nxt = chan_nxt + 4'd1;
    end
    if (s1_req_r.pressed_mask[BTN_DOWN] && (chan_nxt != 4'd0)) begin
      chan_nxt = chan_nxt - 4'd1;
    end
  end

  assign q_push = s1_adv && !s1_req_r.req_type && (n != 3'd0);
  assign q_plan = '{msgs: msgs, last_idx: 2'(n - 3'd1)};

  // controller state, updated once per frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_r  <= 1'b0;
      ox_r   <= '0;
      oy_r   <= '0;
      held_r <= '0;
      oct_r  <= OCT_RST;
      chan_r <= '0;
    end else if (s1_adv && !s1_req_r.req_type) begin
      pen_r  <= pen_nxt;
      ox_r   <= ox_nxt;
      oy_r   <= oy_nxt;
      held_r <= held_nxt;
      oct_r  <= oct_nxt;
      chan_r <= chan_nxt;
    end
  end

endmodule

FILE: sv/tmc_back.sv
// back end: walks through each queued plan and sends one message per cycle while the receiver takes them
module tmc_back
  import tmc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  plan_t    plan,
  input  logic     q_empty,
  output logic     q_pop,
  output logic     out_empty,
  input  logic     out_pop,
  output out_res_t out_data
);

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  out_res_t   res_r;
  msg_t       cur;
  logic       is_last;
  logic       load;

  assign cur     = plan.msgs[idx_r];
  assign is_last = (idx_r == plan.last_idx);
  assign load    = !q_empty && (!valid_r || out_pop);
  assign q_pop   = load && is_last;

  // message index and output valid
  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = is_last ? 2'd0 : idx_r + 2'd1;
    end else if (out_pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= '{midi_status: cur.status, data_one: cur.d1, data_two: cur.d2,
                 last_of_run: is_last};
    end
  end

  assign out_empty = !valid_r;
  assign out_data  = res_r;

endmodule

FILE: sv/touch_to_midi_controller.sv
// top level of the touch to midi controller: register port and front, queue, back
//
// Requests enter through a queue-like port: a request is taken when push is high and
// full is low. A request is either a frame of pen and button events or a load of one
// key table entry. Results leave the same way: the oldest midi message sits on
// out_data while empty is low and is taken when pop is high.
// A frame gives zero to four messages; last_of_run marks the final one of a frame.
// Table loads and frames with nothing to say give no result.
// A request passes through the classify stage register, the plan queue and the
// output register before its first message shows on out_data. A request can be
// taken every cycle while full is low; the back end sends one message per cycle
// while the receiver takes them, and a two-entry plan queue absorbs the difference.
// When the receiver stalls, the output register holds, then the plan queue fills,
// then full rises and holds the front.
// Reset clears the queue, the output and the controller state (pen idle, octave 2,
// channel 0) and loads the key area registers with their defaults; the key table
// holds no defined contents and must be loaded before the keys are played.
// The key area registers sit on an APB-style port at byte addresses 0, 4, 8 and 12.
// Write them only while the block is idle; the block itself does not enforce it.
module touch_to_midi_controller
  import tmc_pkg::*;
#(
  parameter int TABLE_ROWS = 5,
  parameter int TABLE_COLS = 28
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  in_req_t     in_data,
  output logic        empty,
  input  logic        pop,
  output out_res_t    out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [4:0] col_r, row_r, cols_r;
  logic [2:0] rows_r;
  logic       cfg_wr;
  reg_idx_t   reg_sel;
  area_cfg_t  area;

  logic       q_push, q_full, q_pop, q_empty;
  plan_t      q_wr_plan, q_rd_plan;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = reg_idx_t'(paddr[3:2]);

  // key area registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= AREA_COL_RST;
      row_r  <= AREA_ROW_RST;
      cols_r <= AREA_COLS_RST;
      rows_r <= AREA_ROWS_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_AREA_COL:  col_r  <= pwdata[4:0];
        REG_AREA_ROW:  row_r  <= pwdata[4:0];
        REG_AREA_COLS: cols_r <= pwdata[4:0];
        REG_AREA_ROWS: rows_r <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_sel)
      REG_AREA_COL:  prdata = {27'b0, col_r};
      REG_AREA_ROW:  prdata = {27'b0, row_r};
      REG_AREA_COLS: prdata = {27'b0, cols_r};
      REG_AREA_ROWS: prdata = {29'b0, rows_r};
      default:       prdata = '0;
    endcase
  end

  assign area = '{col: col_r, row: row_r, cols: cols_r, rows: rows_r};

  tmc_front #(
    .TABLE_ROWS (TABLE_ROWS),
    .TABLE_COLS (TABLE_COLS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .area    (area),
    .q_push  (q_push),
    .q_plan  (q_wr_plan),
    .q_full  (q_full)
  );

  tmc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_plan (q_wr_plan),
    .full    (q_full),
    .pop     (q_pop),
    .rd_plan (q_rd_plan),
    .empty   (q_empty)
  );

  tmc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .plan      (q_rd_plan),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_empty (empty),
    .out_pop   (pop),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // the front never offers a plan to a full queue
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("plan offered to a full queue");

  // the back only retires plans that are there
  a_pop_has_plan: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("plan retired from an empty queue");

  // retiring a plan puts its final message on the output
  a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (!empty && out_data.last_of_run))
    else $error("plan retired without its final message on the output");
`endif

endmodule
